>>> sv/tlptm_pkg.sv
`timescale 1ns / 1ps
// Shared constants, mode and status codes and state type of the page table manager.
package tlptm_pkg;

  localparam int NUM_PAGES_DEF      = 256;
  localparam int RESERVED_PAGES_DEF = 16;
  localparam int VALID_BIT_POS_DEF  = 9;

  localparam int DIR_SHIFT  = 22;
  localparam int PAGE_SHIFT = 12;
  localparam int SLOTS      = 1024;
  localparam int IDX_W      = 10;

  localparam logic [2:0] MODE_TRANSLATE = 3'd0;
  localparam logic [2:0] MODE_MAP       = 3'd1;
  localparam logic [2:0] MODE_UNMAP     = 3'd2;
  localparam logic [2:0] MODE_ALLOC     = 3'd3;
  localparam logic [2:0] MODE_RELEASE   = 3'd4;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_NOT_MAPPED = 3'd1;
  localparam logic [2:0] ST_NO_FREE    = 3'd2;
  localparam logic [2:0] ST_BAD_FRAME  = 3'd3;
  localparam logic [2:0] ST_USED       = 3'd4;
  localparam logic [2:0] ST_UNDERFLOW  = 3'd5;

  localparam logic [15:0] CNT_MAX = 16'hffff;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_DIR,
    S_TBL,
    S_CNT,
    S_FINC,
    S_CLR,
    S_ALLOC,
    S_AREAD,
    S_AINC
  } state_t;

endpackage

>>> sv/two_level_page_table_manager.sv
`timescale 1ns / 1ps
// Top level of the two-level page table manager with its reference-counted frame pool.
//
// A command is transferred when start is high and busy is low; its result appears on the
// result ports for exactly one cycle, marked by done, and the receiver cannot stall it.
// All state lives in synchronous memories with one write and one registered read port
// each (directory, second-level tables, reference counts and the free-frame stack), and a
// sequencer walks one command at a time through them. Allocating a frame, whether by the
// allocate command or by a map whose directory entry is invalid, clears the new frame's
// 1024 table slots one per cycle. A new command can be transferred in the cycle that
// shows the previous result.
// After reset an initialisation pass clears the directory and loads the counts and the
// free stack; busy stays high throughout it.
module two_level_page_table_manager #(
  parameter int NUM_PAGES      = tlptm_pkg::NUM_PAGES_DEF,
  parameter int RESERVED_PAGES = tlptm_pkg::RESERVED_PAGES_DEF,
  parameter int VALID_BIT_POS  = tlptm_pkg::VALID_BIT_POS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  mode,
  input  logic [31:0] virt_addr,
  input  logic [7:0]  frame_in,
  input  logic [11:0] permission,
  output logic        done,
  output logic [2:0]  status,
  output logic [7:0]  frame_out,
  output logic [31:0] phys_page_addr,
  output logic [7:0]  table_frame,
  output logic [15:0] ref_count
);

  // Frame numbers need FW bits; the stack top needs one more value than there are frames.
  localparam int FW       = $clog2(NUM_PAGES);
  localparam int TW       = $clog2(NUM_PAGES + 1);
  localparam int RSV      = (RESERVED_PAGES < NUM_PAGES) ? RESERVED_PAGES : NUM_PAGES;
  localparam int INIT_LEN = (NUM_PAGES > tlptm_pkg::SLOTS) ? NUM_PAGES : tlptm_pkg::SLOTS;
  localparam int CW       = $clog2(INIT_LEN);
  localparam int TAW      = FW + tlptm_pkg::IDX_W;

  localparam logic [31:0] VBIT = 32'(1) << VALID_BIT_POS;

  // Sequencer state and the command held while it is worked on.
  tlptm_pkg::state_t state, state_next;
  logic [CW-1:0] idx;
  logic [2:0]    mode_r;
  logic [31:0]   va_r;
  logic [7:0]    fin_r;
  logic [11:0]   perm_r;
  logic [FW-1:0] tf_r;
  logic [FW-1:0] f_r;
  logic [FW-1:0] pop_r;
  logic [15:0]   cntfin_r;
  logic          under_r;
  logic [TW-1:0] free_top, free_top_next;

  // The four memories and their ports.
  logic [31:0] dir_mem [tlptm_pkg::SLOTS];
  logic [31:0] tbl_mem [NUM_PAGES * tlptm_pkg::SLOTS];
  logic [15:0] cnt_mem [NUM_PAGES];
  logic [FW-1:0] stk_mem [NUM_PAGES];

  logic                       dir_we, dir_re;
  logic [tlptm_pkg::IDX_W-1:0] dir_waddr, dir_raddr;
  logic [31:0]                dir_wdata, dir_q;
  logic                       tbl_we, tbl_re;
  logic [TAW-1:0]             tbl_waddr, tbl_raddr;
  logic [31:0]                tbl_wdata, tbl_q;
  logic                       cnt_we, cnt_re;
  logic [FW-1:0]              cnt_waddr, cnt_raddr;
  logic [15:0]                cnt_wdata, cnt_q;
  logic                       stk_we, stk_re;
  logic [FW-1:0]              stk_waddr, stk_raddr, stk_wdata, stk_q;

  // Result registers and their next values.
  logic        done_next;
  logic [2:0]  status_next;
  logic [7:0]  frame_out_next, table_frame_next;
  logic [31:0] phys_next;
  logic [15:0] ref_count_next;

  // Decoded views of the command and of the words just read.
  logic [9:0]  di, ti;
  logic        dv, ev, tf_ok, f_ok, fin_ok, same, stk_empty, stk_full;
  logic [19:0] tf20, f20;
  logic [31:0] entry;
  logic [15:0] finc, cntm1;

  assign di        = va_r[31:22];
  assign ti        = va_r[21:12];
  assign dv        = (dir_q & VBIT) != 32'd0;
  assign tf20      = dir_q[31:12];
  assign tf_ok     = 32'(tf20) < NUM_PAGES;
  assign ev        = (tbl_q & VBIT) != 32'd0;
  assign f20       = tbl_q[31:12];
  assign f_ok      = 32'(f20) < NUM_PAGES;
  assign fin_ok    = 32'(fin_r) < NUM_PAGES;
  assign same      = f20 == 20'(fin_r);
  assign stk_empty = free_top == '0;
  assign stk_full  = 32'(free_top) >= NUM_PAGES;
  assign entry     = {12'd0, fin_r, perm_r} | VBIT;
  assign finc      = (cntfin_r == tlptm_pkg::CNT_MAX) ? cntfin_r : cntfin_r + 16'd1;
  assign cntm1     = cnt_q - 16'd1;
  assign busy      = state != tlptm_pkg::S_IDLE;

  // Memories: one write and one registered read per cycle each.
  always_ff @(posedge clk) begin
    if (dir_we) dir_mem[dir_waddr] <= dir_wdata;
    if (dir_re) dir_q <= dir_mem[dir_raddr];
  end

  always_ff @(posedge clk) begin
    if (tbl_we) tbl_mem[tbl_waddr] <= tbl_wdata;
    if (tbl_re) tbl_q <= tbl_mem[tbl_raddr];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
    if (cnt_re) cnt_q <= cnt_mem[cnt_raddr];
  end

  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[stk_waddr] <= stk_wdata;
    if (stk_re) stk_q <= stk_mem[stk_raddr];
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      tlptm_pkg::S_INIT: begin
        if (32'(idx) == INIT_LEN - 1) state_next = tlptm_pkg::S_IDLE;
      end
      tlptm_pkg::S_IDLE: begin
        if (start) state_next = tlptm_pkg::S_DIR;
      end
      tlptm_pkg::S_DIR: begin
        state_next = tlptm_pkg::S_IDLE;
        case (mode_r)
          tlptm_pkg::MODE_TRANSLATE, tlptm_pkg::MODE_UNMAP: begin
            if (dv && tf_ok) state_next = tlptm_pkg::S_TBL;
          end
          tlptm_pkg::MODE_MAP: begin
            if (fin_ok && dv && tf_ok) state_next = tlptm_pkg::S_TBL;
            else if (fin_ok && !dv && !stk_empty) state_next = tlptm_pkg::S_CLR;
          end
          tlptm_pkg::MODE_ALLOC: begin
            if (!stk_empty) state_next = tlptm_pkg::S_CLR;
          end
          default: state_next = tlptm_pkg::S_IDLE;
        endcase
      end
      tlptm_pkg::S_TBL: begin
        state_next = tlptm_pkg::S_IDLE;
        case (mode_r)
          tlptm_pkg::MODE_TRANSLATE, tlptm_pkg::MODE_UNMAP: begin
            if (ev && f_ok) state_next = tlptm_pkg::S_CNT;
          end
          tlptm_pkg::MODE_MAP: begin
            if (ev && f_ok && !same) state_next = tlptm_pkg::S_CNT;
          end
          default: state_next = tlptm_pkg::S_IDLE;
        endcase
      end
      tlptm_pkg::S_CNT: begin
        state_next = (mode_r == tlptm_pkg::MODE_MAP) ? tlptm_pkg::S_FINC : tlptm_pkg::S_IDLE;
      end
      tlptm_pkg::S_FINC:  state_next = tlptm_pkg::S_IDLE;
      tlptm_pkg::S_CLR: begin
        if (idx[tlptm_pkg::IDX_W-1:0] == '1) begin
          state_next = (mode_r == tlptm_pkg::MODE_MAP) ? tlptm_pkg::S_ALLOC
                                                       : tlptm_pkg::S_IDLE;
        end
      end
      tlptm_pkg::S_ALLOC: state_next = tlptm_pkg::S_AREAD;
      tlptm_pkg::S_AREAD: state_next = tlptm_pkg::S_AINC;
      tlptm_pkg::S_AINC:  state_next = tlptm_pkg::S_IDLE;
      default:            state_next = tlptm_pkg::S_IDLE;
    endcase
  end

  // Memory accesses, stack top and results.
  always_comb begin
    dir_we = 1'b0; dir_re = 1'b0; dir_waddr = di; dir_raddr = virt_addr[31:22];
    dir_wdata = '0;
    tbl_we = 1'b0; tbl_re = 1'b0; tbl_waddr = {tf_r, ti}; tbl_wdata = '0;
    tbl_raddr = {tf20[FW-1:0], ti};
    cnt_we = 1'b0; cnt_re = 1'b0; cnt_waddr = f_r; cnt_wdata = '0;
    cnt_raddr = FW'(frame_in);
    stk_we = 1'b0; stk_re = 1'b0; stk_waddr = FW'(free_top); stk_wdata = f_r;
    stk_raddr = FW'(free_top - TW'(1));
    free_top_next = free_top;
    done_next = 1'b0; status_next = tlptm_pkg::ST_OK; frame_out_next = '0;
    phys_next = '0; table_frame_next = '0; ref_count_next = '0;

    case (state)
      tlptm_pkg::S_INIT: begin
        // Clear the directory and load counts and the free stack, one row a cycle.
        dir_we    = 32'(idx) < tlptm_pkg::SLOTS;
        dir_waddr = idx[tlptm_pkg::IDX_W-1:0];
        cnt_we    = 32'(idx) < NUM_PAGES;
        cnt_waddr = FW'(idx);
        cnt_wdata = (32'(idx) < RSV) ? 16'd1 : 16'd0;
        stk_we    = (32'(idx) >= RSV) && (32'(idx) < NUM_PAGES);
        stk_waddr = FW'(idx - CW'(RSV));
        stk_wdata = FW'(idx);
      end

      tlptm_pkg::S_IDLE: begin
        dir_re = start;
        stk_re = start;
        cnt_re = start;
      end

      tlptm_pkg::S_DIR: begin
        tbl_re = 1'b1;
        case (mode_r)
          tlptm_pkg::MODE_TRANSLATE: begin
            if (!dv || !tf_ok) begin
              done_next        = 1'b1;
              status_next      = dv ? tlptm_pkg::ST_BAD_FRAME : tlptm_pkg::ST_NOT_MAPPED;
              phys_next        = '1;
              table_frame_next = dv ? tf20[7:0] : 8'd0;
            end
          end
          tlptm_pkg::MODE_MAP: begin
            if (!fin_ok || (dv && !tf_ok)) begin
              done_next        = 1'b1;
              status_next      = tlptm_pkg::ST_BAD_FRAME;
              table_frame_next = dv ? tf20[7:0] : 8'd0;
            end else if (!dv && stk_empty) begin
              done_next      = 1'b1;
              status_next    = tlptm_pkg::ST_NO_FREE;
              ref_count_next = cnt_q;
            end else if (!dv) begin
              free_top_next = free_top - TW'(1);
              cnt_we        = 1'b1;
              cnt_waddr     = stk_q;
            end
          end
          tlptm_pkg::MODE_UNMAP: begin
            if (!dv || !tf_ok) begin
              done_next        = 1'b1;
              status_next      = dv ? tlptm_pkg::ST_BAD_FRAME : tlptm_pkg::ST_NOT_MAPPED;
              table_frame_next = dv ? tf20[7:0] : 8'd0;
            end
          end
          tlptm_pkg::MODE_ALLOC: begin
            if (stk_empty) begin
              done_next   = 1'b1;
              status_next = tlptm_pkg::ST_NO_FREE;
            end else begin
              free_top_next = free_top - TW'(1);
              cnt_we        = 1'b1;
              cnt_waddr     = stk_q;
            end
          end
          tlptm_pkg::MODE_RELEASE: begin
            done_next = 1'b1;
            if (!fin_ok) begin
              status_next = tlptm_pkg::ST_BAD_FRAME;
            end else if (cnt_q != 16'd0) begin
              status_next    = tlptm_pkg::ST_USED;
              ref_count_next = cnt_q;
            end else if (!stk_full) begin
              stk_we        = 1'b1;
              stk_wdata     = FW'(fin_r);
              free_top_next = free_top + TW'(1);
            end
          end
          default: done_next = 1'b1;
        endcase
      end

      tlptm_pkg::S_TBL: begin
        table_frame_next = 8'(tf_r);
        cnt_raddr        = f20[FW-1:0];
        case (mode_r)
          tlptm_pkg::MODE_TRANSLATE: begin
            if (!ev) begin
              done_next   = 1'b1;
              status_next = tlptm_pkg::ST_NOT_MAPPED;
              phys_next   = '1;
            end else if (!f_ok) begin
              done_next      = 1'b1;
              status_next    = tlptm_pkg::ST_BAD_FRAME;
              phys_next      = {f20, 12'd0};
              frame_out_next = f20[7:0];
            end else begin
              cnt_re = 1'b1;
            end
          end
          tlptm_pkg::MODE_MAP: begin
            if (ev && !f_ok) begin
              done_next   = 1'b1;
              status_next = tlptm_pkg::ST_BAD_FRAME;
            end else if (ev && same) begin
              done_next      = 1'b1;
              tbl_we         = 1'b1;
              tbl_wdata      = entry;
              ref_count_next = cntfin_r;
            end else if (ev) begin
              cnt_re = 1'b1;
            end else begin
              done_next      = 1'b1;
              tbl_we         = 1'b1;
              tbl_wdata      = entry;
              cnt_we         = 1'b1;
              cnt_waddr      = FW'(fin_r);
              cnt_wdata      = finc;
              ref_count_next = finc;
            end
          end
          tlptm_pkg::MODE_UNMAP: begin
            if (!ev || !f_ok) begin
              done_next   = 1'b1;
              status_next = ev ? tlptm_pkg::ST_BAD_FRAME : tlptm_pkg::ST_NOT_MAPPED;
            end else begin
              cnt_re = 1'b1;
            end
          end
          default: done_next = 1'b1;
        endcase
      end

      tlptm_pkg::S_CNT: begin
        table_frame_next = 8'(tf_r);
        if (mode_r == tlptm_pkg::MODE_TRANSLATE) begin
          done_next      = 1'b1;
          phys_next      = {tbl_q[31:12], 12'd0};
          frame_out_next = tbl_q[19:12];
          ref_count_next = cnt_q;
        end else begin
          // Drop the old mapping; a map writes its own entry into the slot in its place.
          tbl_we    = 1'b1;
          tbl_wdata = (mode_r == tlptm_pkg::MODE_MAP) ? entry : 32'd0;
          if (cnt_q != 16'd0) begin
            cnt_we    = 1'b1;
            cnt_wdata = cntm1;
            if (cntm1 == 16'd0 && !stk_full) begin
              stk_we        = 1'b1;
              free_top_next = free_top + TW'(1);
            end
          end
          if (mode_r != tlptm_pkg::MODE_MAP) begin
            done_next      = 1'b1;
            status_next    = (cnt_q == 16'd0) ? tlptm_pkg::ST_UNDERFLOW : tlptm_pkg::ST_OK;
            ref_count_next = (cnt_q == 16'd0) ? 16'd0 : cntm1;
          end
        end
      end

      tlptm_pkg::S_FINC: begin
        done_next        = 1'b1;
        cnt_we           = 1'b1;
        cnt_waddr        = FW'(fin_r);
        cnt_wdata        = finc;
        status_next      = under_r ? tlptm_pkg::ST_UNDERFLOW : tlptm_pkg::ST_OK;
        ref_count_next   = finc;
        table_frame_next = 8'(tf_r);
      end

      tlptm_pkg::S_CLR: begin
        tbl_we    = 1'b1;
        tbl_waddr = {pop_r, idx[tlptm_pkg::IDX_W-1:0]};
        if (idx[tlptm_pkg::IDX_W-1:0] == '1 && mode_r == tlptm_pkg::MODE_ALLOC) begin
          done_next      = 1'b1;
          frame_out_next = 8'(pop_r);
        end
      end

      tlptm_pkg::S_ALLOC: begin
        dir_we    = 1'b1;
        dir_wdata = {20'(pop_r), 12'd0} | VBIT;
        cnt_we    = 1'b1;
        cnt_waddr = pop_r;
        cnt_wdata = 16'd1;
        tbl_we    = 1'b1;
        tbl_waddr = {pop_r, ti};
        tbl_wdata = entry;
      end

      tlptm_pkg::S_AREAD: begin
        cnt_re    = 1'b1;
        cnt_raddr = FW'(fin_r);
      end

      tlptm_pkg::S_AINC: begin
        done_next        = 1'b1;
        cnt_we           = 1'b1;
        cnt_waddr        = FW'(fin_r);
        cnt_wdata        = (cnt_q == tlptm_pkg::CNT_MAX) ? cnt_q : cnt_q + 16'd1;
        ref_count_next   = cnt_wdata;
        table_frame_next = 8'(pop_r);
      end

      default: done_next = 1'b0;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= tlptm_pkg::S_INIT;
      idx      <= '0;
      free_top <= TW'(NUM_PAGES - RSV);
      done     <= 1'b0;
    end else begin
      state    <= state_next;
      free_top <= free_top_next;
      done     <= done_next;
      if (state == tlptm_pkg::S_INIT || state == tlptm_pkg::S_CLR) idx <= idx + CW'(1);
      else idx <= '0;
    end
  end

  // Command and intermediate payload registers.
  always_ff @(posedge clk) begin
    if (state == tlptm_pkg::S_IDLE && start) begin
      mode_r <= mode;
      va_r   <= virt_addr;
      fin_r  <= frame_in;
      perm_r <= permission;
    end
    if (state == tlptm_pkg::S_DIR) begin
      tf_r     <= tf20[FW-1:0];
      pop_r    <= stk_q;
      cntfin_r <= cnt_q;
    end
    if (state == tlptm_pkg::S_TBL) f_r <= f20[FW-1:0];
    if (state == tlptm_pkg::S_CNT) under_r <= cnt_q == 16'd0;
    status         <= status_next;
    frame_out      <= frame_out_next;
    phys_page_addr <= phys_next;
    table_frame    <= table_frame_next;
    ref_count      <= ref_count_next;
  end

  // A result is only ever shown once the sequencer is back and ready for the next command.
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result shown while the sequencer is still busy");

  // A transferred command always occupies the sequencer in the following cycle.
  a_start_busy: assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("command transfer did not start the sequencer");

  // The free stack never holds more frames than exist.
  a_top_range: assert property (@(posedge clk) disable iff (rst)
      32'(free_top) <= NUM_PAGES)
    else $error("free stack top beyond the frame count");

endmodule
